// File: rtl/hgcs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the HSV gradient color shift block.
package hgcs_pkg;

	localparam int CHANNEL_FRAC_BITS_DEF = 12;

	// Configuration register indexes
	localparam logic REG_START_COLOR  = 1'b0;
	localparam logic REG_TARGET_COLOR = 1'b1;

	// Hue in degrees with 16 fraction bits
	localparam int HUE_W = 25;
	localparam logic [HUE_W-1:0] DEG60  = 25'd3932160;
	localparam logic [HUE_W-1:0] DEG120 = 25'd7864320;
	localparam logic [HUE_W-1:0] DEG180 = 25'd11796480;
	localparam logic [HUE_W-1:0] DEG240 = 25'd15728640;
	localparam logic [HUE_W-1:0] DEG300 = 25'd19660800;
	localparam logic [HUE_W-1:0] DEG360 = 25'd23592960;

	// Q0.16 unit values hold 0..65536
	localparam int UNIT_W = 17;

	typedef struct packed {
		logic        [HUE_W-1:0]  hue_base;
		logic signed [HUE_W-1:0]  hue_delta;
		logic        [UNIT_W-1:0] sat_base;
		logic signed [UNIT_W:0]   sat_delta;
		logic        [UNIT_W-1:0] val_base;
		logic signed [UNIT_W:0]   val_delta;
	} hgcs_hsv_t;

endpackage

// File: rtl/hgcs_hsv_calc.sv
`timescale 1ns / 1ps
// Serial RGB to HSV conversion of the two configured colors, one quotient bit per cycle.
module hgcs_hsv_calc import hgcs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [23:0]     start_color,
	input  logic [23:0]     target_color,
	output logic            busy,
	output hgcs_hsv_t       hsv
);

	localparam int DIV_W = 33;
	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam int SLOTS = 6;
	localparam int STEP_W = 3;

	localparam logic [STEP_W-1:0] SLOT_VS = 3'd0;
	localparam logic [STEP_W-1:0] SLOT_SS = 3'd1;
	localparam logic [STEP_W-1:0] SLOT_HS = 3'd2;
	localparam logic [STEP_W-1:0] SLOT_VT = 3'd3;
	localparam logic [STEP_W-1:0] SLOT_ST = 3'd4;
	localparam logic [STEP_W-1:0] SLOT_HT = 3'd5;

	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN, ST_FIN} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [7:0]         rem_q;
	logic [DIV_W-1:0]   quo_q;
	logic [7:0]         div_q;
	logic [HUE_W-1:0]   res_q [SLOTS];

	logic [23:0]        col;
	logic [7:0]         r, g, b, mx, mn, dl;
	logic signed [11:0] n;
	logic [DIV_W-1:0]   dividend;
	logic [7:0]         divisor;
	logic [8:0]         trial;
	logic               qbit;
	logic signed [HUE_W:0] hd;
	logic signed [HUE_W:0] hd_fold;

	assign col = (step_q < SLOT_VT) ? start_color : target_color;
	assign r = col[23:16];
	assign g = col[15:8];
	assign b = col[7:0];

	always_comb begin
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		dl = mx - mn;
		// sector numerator, ties go red then green
		if (mx == r) begin
			n = $signed({4'b0, g}) - $signed({4'b0, b});
			if (n < 0) n = n + $signed({4'b0, dl}) * 12'sd6;
		end else if (mx == g) begin
			n = $signed({4'b0, b}) - $signed({4'b0, r}) + $signed({3'b0, dl, 1'b0});
		end else begin
			n = $signed({4'b0, r}) - $signed({4'b0, g}) + $signed({2'b0, dl, 2'b0});
		end
		unique case (step_q) inside
			SLOT_SS, SLOT_ST: begin
				dividend = {1'b0, dl, 16'b0};
				divisor  = mx;
			end
			default: begin
				dividend = DIV_W'(DEG60 * n[10:0]);
				divisor  = dl;
			end
		endcase
	end

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign qbit  = (trial >= {1'b0, div_q});

	assign hd = $signed({1'b0, res_q[SLOT_HT]}) - $signed({1'b0, res_q[SLOT_HS]});
	always_comb begin
		if (hd > $signed({1'b0, DEG180}))
			hd_fold = hd - $signed({1'b0, DEG360});
		else if (hd < -$signed({1'b0, DEG180}))
			hd_fold = hd + $signed({1'b0, DEG360});
		else
			hd_fold = hd;
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			div_q   <= '0;
			hsv     <= '0;
			for (int i = 0; i < SLOTS; i++) res_q[i] <= '0;
		end else if (go) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_LOAD: begin
					if (step_q == SLOT_VS || step_q == SLOT_VT) begin
						// max * 65536 / 255 is max * 257, plus one at full scale
						res_q[step_q] <= HUE_W'({mx, mx}) + HUE_W'(mx == 8'hFF);
						step_q        <= step_q + 1'b1;
					end else begin
						quo_q   <= dividend;
						rem_q   <= '0;
						div_q   <= divisor;
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == CNT_W'(DIV_W)) begin
						// quotient complete; gray colors give zero hue and saturation
						res_q[step_q] <= (div_q == 8'd0) ? '0 : quo_q[HUE_W-1:0];
						if (step_q == SLOT_HT) begin
							state_q <= ST_FIN;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end else begin
						rem_q <= qbit ? 8'(trial - {1'b0, div_q}) : trial[7:0];
						quo_q <= {quo_q[DIV_W-2:0], qbit};
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					hsv.hue_base  <= res_q[SLOT_HS];
					hsv.hue_delta <= hd_fold[HUE_W-1:0];
					hsv.sat_base  <= res_q[SLOT_SS][UNIT_W-1:0];
					hsv.sat_delta <= $signed({1'b0, res_q[SLOT_ST][UNIT_W-1:0]})
						- $signed({1'b0, res_q[SLOT_SS][UNIT_W-1:0]});
					hsv.val_base  <= res_q[SLOT_VS][UNIT_W-1:0];
					hsv.val_delta <= $signed({1'b0, res_q[SLOT_VT][UNIT_W-1:0]})
						- $signed({1'b0, res_q[SLOT_VS][UNIT_W-1:0]});
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/hgcs_pipe.sv
`timescale 1ns / 1ps
// Seven-stage datapath: progress, blend, hue wrap, HSV to RGB, channel rescale.
module hgcs_pipe import hgcs_pkg::*; #(
	parameter int CHANNEL_FRAC_BITS = CHANNEL_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [15:0]            heat,
	input  hgcs_hsv_t                     hsv,
	output logic                          out_valid,
	output logic [CHANNEL_FRAC_BITS:0]    red,
	output logic [CHANNEL_FRAC_BITS:0]    green,
	output logic [CHANNEL_FRAC_BITS:0]    blue
);

	localparam int OUT_W = CHANNEL_FRAC_BITS + 1;
	localparam int SUM_W = UNIT_W + CHANNEL_FRAC_BITS + 1;
	localparam logic [27:0] RECIP25 = 28'd171798692;   // ceil(2^32 / 25)
	localparam logic [30:0] RECIP60 = 31'd1145324613;  // ceil(2^36 / 60)
	localparam logic signed [15:0] HEAT_FULL = 16'sd25600;
	localparam logic [UNIT_W-1:0] ONE = 17'd65536;

	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

	function automatic logic [OUT_W-1:0] to_chan(input logic [UNIT_W-1:0] x);
		logic [SUM_W-1:0] sh;
		logic [SUM_W-17:0] y;
		sh = {1'b0, x, {CHANNEL_FRAC_BITS{1'b0}}} + SUM_W'(32768);
		y  = sh[SUM_W-1:16];
		if (y > (SUM_W-16)'(1) << CHANNEL_FRAC_BITS)
			y = (SUM_W-16)'(1) << CHANNEL_FRAC_BITS;
		return y[OUT_W-1:0];
	endfunction

	// stage 1: progress Q0.16
	logic                valid_s1;
	logic [UNIT_W-1:0]   p_s1;
	logic [48:0]         p_prod;
	logic [UNIT_W-1:0]   p_next;

	assign p_prod = {heat[14:0], 6'b0} * RECIP25;
	always_comb begin
		if (heat <= 16'sd0)          p_next = '0;
		else if (heat >= HEAT_FULL)  p_next = ONE;
		else                         p_next = p_prod[48:32];
	end

	// stage 2: blend products
	logic                valid_s2;
	logic signed [42:0]  hprod_s2;
	logic signed [35:0]  sprod_s2, vprod_s2;

	// stage 3: blended HSV
	logic                valid_s3;
	logic [HUE_W-1:0]    h_s3;
	logic [UNIT_W-1:0]   s_s3, v_s3;
	logic signed [26:0]  hq, hsum, hwrap;
	logic signed [19:0]  sq, vq;
	logic signed [42:0]  hbias;
	logic signed [35:0]  sbias, vbias;
	logic signed [20:0]  ssum, vsum;

	assign hbias = hprod_s2 + (hprod_s2[42] ? 43'sd65535 : 43'sd0);
	assign sbias = sprod_s2 + (sprod_s2[35] ? 36'sd65535 : 36'sd0);
	assign vbias = vprod_s2 + (vprod_s2[35] ? 36'sd65535 : 36'sd0);
	assign hq = hbias[42:16];
	assign sq = sbias[35:16];
	assign vq = vbias[35:16];
	assign hsum = $signed({2'b0, hsv.hue_base}) + hq;
	assign ssum = $signed({4'b0, hsv.sat_base}) + sq;
	assign vsum = $signed({4'b0, hsv.val_base}) + vq;
	always_comb begin
		if (hsum < 27'sd0)                            hwrap = hsum + $signed({2'b0, DEG360});
		else if (hsum >= $signed({2'b0, DEG360}))     hwrap = hsum - $signed({2'b0, DEG360});
		else                                          hwrap = hsum;
	end

	// stage 4: chroma, hue within 120 degrees, sector
	logic                valid_s4;
	logic [UNIT_W-1:0]   c_s4, v_s4;
	logic [22:0]         t_s4;
	logic [2:0]          sec_s4;
	logic [33:0]         vs_prod;
	logic [HUE_W-1:0]    t_next;
	logic [2:0]          sec_next;

	assign vs_prod = v_s3 * s_s3;
	always_comb begin
		if (h_s3 >= DEG240)      t_next = h_s3 - DEG240;
		else if (h_s3 >= DEG120) t_next = h_s3 - DEG120;
		else                     t_next = h_s3;
		if (h_s3 < DEG60)        sec_next = SEC_RY;
		else if (h_s3 < DEG120)  sec_next = SEC_YG;
		else if (h_s3 < DEG180)  sec_next = SEC_GC;
		else if (h_s3 < DEG240)  sec_next = SEC_CB;
		else if (h_s3 < DEG300)  sec_next = SEC_BM;
		else                     sec_next = SEC_MR;
	end

	// stage 5: triangle weight
	logic                valid_s5;
	logic [UNIT_W-1:0]   c_s5, v_s5, w_s5;
	logic [2:0]          sec_s5;
	logic [53:0]         f_prod;
	logic [UNIT_W-1:0]   f;
	logic [UNIT_W:0]     w_next;

	assign f_prod = t_s4 * RECIP60;
	assign f = f_prod[52:36];
	assign w_next = (f >= ONE) ? (18'd131072 - {1'b0, f}) : {1'b0, f};

	// stage 6: second component and offset
	logic                valid_s6;
	logic [UNIT_W-1:0]   c_s6, x_s6, m_s6;
	logic [2:0]          sec_s6;
	logic [33:0]         cw_prod;

	assign cw_prod = c_s5 * w_s5;

	// stage 7: channel assembly
	logic [UNIT_W-1:0]   rr, gg, bb;
	always_comb begin
		case (sec_s6)
			SEC_RY:  begin rr = c_s6; gg = x_s6; bb = '0;   end
			SEC_YG:  begin rr = x_s6; gg = c_s6; bb = '0;   end
			SEC_GC:  begin rr = '0;   gg = c_s6; bb = x_s6; end
			SEC_CB:  begin rr = '0;   gg = x_s6; bb = c_s6; end
			SEC_BM:  begin rr = x_s6; gg = '0;   bb = c_s6; end
			default: begin rr = c_s6; gg = '0;   bb = x_s6; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			out_valid <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		p_s1     <= p_next;
		hprod_s2 <= hsv.hue_delta * $signed({1'b0, p_s1});
		sprod_s2 <= hsv.sat_delta * $signed({1'b0, p_s1});
		vprod_s2 <= hsv.val_delta * $signed({1'b0, p_s1});
		h_s3     <= hwrap[HUE_W-1:0];
		s_s3     <= ssum[UNIT_W-1:0];
		v_s3     <= vsum[UNIT_W-1:0];
		c_s4     <= vs_prod[32:16];
		v_s4     <= v_s3;
		t_s4     <= t_next[22:0];
		sec_s4   <= sec_next;
		c_s5     <= c_s4;
		v_s5     <= v_s4;
		w_s5     <= w_next[UNIT_W-1:0];
		sec_s5   <= sec_s4;
		c_s6     <= c_s5;
		x_s6     <= cw_prod[32:16];
		m_s6     <= v_s5 - c_s5;
		sec_s6   <= sec_s5;
		red      <= to_chan(rr + m_s6);
		green    <= to_chan(gg + m_s6);
		blue     <= to_chan(bb + m_s6);
	end

endmodule

// File: rtl/hsv_gradient_color_shift.sv
`timescale 1ns / 1ps
// Top level: configuration registers, HSV precompute unit and color pipeline.
// An accepted request moves through the registers valid_s1 to valid_s6 and out_valid to its done strobe.
// Throughput: one request per cycle; busy stays low except while the color
// converter runs after a register write (4 divisions, 2 value terms and a
// final output step).
// The receiver cannot stall: each result shows on the outputs for one cycle with done.
// Reset clears both colors to black, so the precomputed HSV terms reset to zero.
module hsv_gradient_color_shift import hgcs_pkg::*; #(
	parameter int CHANNEL_FRAC_BITS = CHANNEL_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [15:0]          heat,
	output logic                        done,
	output logic [CHANNEL_FRAC_BITS:0]  red_out,
	output logic [CHANNEL_FRAC_BITS:0]  green_out,
	output logic [CHANNEL_FRAC_BITS:0]  blue_out,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [23:0]                 cfg_data
);

	logic [23:0] start_color_q;
	logic [23:0] target_color_q;
	hgcs_hsv_t   hsv;
	logic        accept;

	// both register indexes are live, so any write reruns the conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q  <= '0;
			target_color_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_COLOR:  start_color_q  <= cfg_data;
				REG_TARGET_COLOR: target_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// HSV of both colors, hue delta folded to the short way round
	hgcs_hsv_calc u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (cfg_we),
		.start_color  (start_color_q),
		.target_color (target_color_q),
		.busy         (busy),
		.hsv          (hsv)
	);

	assign accept = start & ~busy;

	// one request per cycle while busy is low, no backpressure
	hgcs_pipe #(
		.CHANNEL_FRAC_BITS (CHANNEL_FRAC_BITS)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.heat      (heat),
		.hsv       (hsv),
		.out_valid (done),
		.red       (red_out),
		.green     (green_out),
		.blue      (blue_out)
	);

endmodule
